// ===== rtl/josephus_survivor_ring_queue_core_assert.svh =====
// Assertion macros shared by the ring queue core and its remainder unit.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef JOSEPHUS_SURVIVOR_RING_QUEUE_CORE_ASSERT_SVH
`define JOSEPHUS_SURVIVOR_RING_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define JSRQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define JSRQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/jsrq_pkg.sv =====
// Shared types and constants for the Josephus ring queue core.
// No dependencies; used by jsrq_mod_unit and the top level.
package jsrq_pkg;

  localparam int QUEUE_SLOTS = 128;
  localparam int IDX_W       = $clog2(QUEUE_SLOTS);
  // Entries, counts and indices share one width: at most QUEUE_SLOTS-1 entries.
  localparam int CNT_W       = IDX_W;
  localparam int MAX_LIVE    = QUEUE_SLOTS - 1;
  localparam int PEOPLE_W    = 8;
  localparam int STEP_W      = 16;
  localparam int SURV_W      = 8;
  localparam int STEP_CNT_W  = $clog2(STEP_W);

  // Survivor code for an empty queue (-1).
  localparam logic [SURV_W-1:0] SURV_NONE = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MOD_START,
    S_MOD_WAIT,
    S_ROT_RD,
    S_ROT_WR,
    S_POP_TAKE,
    S_OUT
  } jsrq_state_e;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] dividend;
    logic [CNT_W-1:0]  divisor;
  } jsrq_mod_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] remainder;
  } jsrq_mod_rsp_t;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
    if (int'(idx) == QUEUE_SLOTS - 1) begin
      return '0;
    end else begin
      return idx + IDX_W'(1);
    end
  endfunction

endpackage

// ===== rtl/jsrq_mod_unit.sv =====
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on jsrq_pkg for widths and the request and response structs.
`include "josephus_survivor_ring_queue_core_assert.svh"

module jsrq_mod_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  jsrq_pkg::jsrq_mod_req_t req_i,
  output jsrq_pkg::jsrq_mod_rsp_t rsp_o
);
  import jsrq_pkg::*;

  localparam logic [STEP_CNT_W-1:0] LAST_BIT = STEP_CNT_W'(STEP_W - 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [STEP_CNT_W-1:0] cnt_q, cnt_d;
  logic [STEP_W-1:0]     dvd_q, dvd_d;
  logic [CNT_W-1:0]      rem_q, rem_d;
  logic [CNT_W-1:0]      div_q, div_d;
  logic [CNT_W:0]        trial;
  logic                  fits;

  assign trial = {rem_q, dvd_q[STEP_W-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      dvd_d = {dvd_q[STEP_W-2:0], 1'b0};
      // The partial remainder stays below the divisor, so the trial fits.
      rem_d = fits ? CNT_W'(trial - {1'b0, div_q}) : trial[CNT_W-1:0];
      cnt_d = cnt_q + STEP_CNT_W'(1);
      if (cnt_q == LAST_BIT) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;

  `JSRQ_ASSERT_IMP(a_mod_done_idle, done_q, !busy_q, "remainder done while still busy")
  `JSRQ_ASSERT_IMP(a_mod_rem_below, done_q, rem_q < div_q, "remainder not below divisor")
  `JSRQ_ASSERT_NXT(a_mod_start_busy, req_i.start, busy_q && !done_q, "start did not begin a run")

endmodule

// ===== rtl/josephus_survivor_ring_queue_core.sv =====
// Josephus survivor on a circular queue of QUEUE_SLOTS entries.
// Input channel (in_valid_i/in_ready_o) takes one word: people_count_i (n) and
// step_count_i (k). Output channel (out_valid_o/out_ready_i) returns one word,
// survivor_o, the last entry removed, or -1 when n is zero.
// The queue is loaded with 1..n (n saturates to QUEUE_SLOTS-1), then each
// round rotates (k-1) mod live entries (none for k=0), removes the front entry.
// One word is in flight at a time; in_ready_o is high only when idle.
// Sequence per word: when n is zero the result goes straight to the output
// register; otherwise the core writes n load entries, then for each of the n
// rounds starts the bit-serial remainder unit, waits for its result, performs
// that round's rotations (each a read state and a write state on the queue
// memory, which has one read and one write port), reads the front and pops it.
// The next input word can be taken in the cycle after the result is taken.
// The result sits in an output register until out_ready_i is high; the core
// holds it and waits, doing nothing else. Reset returns the core to idle
// with an empty queue; the memory contents are not cleared.
// Depends on jsrq_pkg and jsrq_mod_unit.
`include "josephus_survivor_ring_queue_core_assert.svh"

module josephus_survivor_ring_queue_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [jsrq_pkg::PEOPLE_W-1:0]       people_count_i,
  input  logic [jsrq_pkg::STEP_W-1:0]         step_count_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [jsrq_pkg::SURV_W-1:0]  survivor_o
);
  import jsrq_pkg::*;

  jsrq_state_e       state_q, state_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [IDX_W-1:0]  tail_q, tail_d;
  logic [CNT_W-1:0]  live_q, live_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [STEP_W-1:0] k_q, k_d;
  logic [CNT_W-1:0]  load_val_q, load_val_d;
  logic [CNT_W-1:0]  turns_q, turns_d;
  logic [SURV_W-1:0] surv_q, surv_d;
  logic [CNT_W-1:0]  n_sat;

  logic [CNT_W-1:0]  mem [QUEUE_SLOTS];
  logic              mem_we;
  logic [CNT_W-1:0]  mem_wdata;
  logic [CNT_W-1:0]  rdata_q;

  jsrq_mod_req_t mod_req;
  jsrq_mod_rsp_t mod_rsp;

  jsrq_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  assign n_sat = (int'(people_count_i) > MAX_LIVE) ? CNT_W'(MAX_LIVE)
                                                    : CNT_W'(people_count_i);

  always_comb begin
    state_d          = state_q;
    head_d           = head_q;
    tail_d           = tail_q;
    live_d           = live_q;
    n_d              = n_q;
    k_d              = k_q;
    load_val_d       = load_val_q;
    turns_d          = turns_q;
    surv_d           = surv_q;
    mem_we           = 1'b0;
    mem_wdata        = rdata_q;
    mod_req.start    = 1'b0;
    mod_req.dividend = (k_q > STEP_W'(1)) ? k_q - STEP_W'(1) : '0;
    mod_req.divisor  = live_q;
    in_ready_o       = 1'b0;
    out_valid_o      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          n_d        = n_sat;
          k_d        = step_count_i;
          head_d     = '0;
          tail_d     = '0;
          live_d     = '0;
          load_val_d = CNT_W'(1);
          if (n_sat == '0) begin
            surv_d  = SURV_NONE;
            state_d = S_OUT;
          end else begin
            state_d = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        mem_we     = 1'b1;
        mem_wdata  = load_val_q;
        tail_d     = idx_inc(tail_q);
        live_d     = live_q + CNT_W'(1);
        load_val_d = load_val_q + CNT_W'(1);
        if (load_val_q == n_q) begin
          state_d = S_MOD_START;
        end
      end
      S_MOD_START: begin
        mod_req.start = 1'b1;
        state_d       = S_MOD_WAIT;
      end
      S_MOD_WAIT: begin
        if (mod_rsp.done) begin
          turns_d = mod_rsp.remainder;
          state_d = S_ROT_RD;
        end
      end
      S_ROT_RD: begin
        // The front entry is read here, so with no turns left it is popped next.
        state_d = (turns_q == '0) ? S_POP_TAKE : S_ROT_WR;
      end
      S_ROT_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_q;
        head_d    = idx_inc(head_q);
        tail_d    = idx_inc(tail_q);
        turns_d   = turns_q - CNT_W'(1);
        state_d   = S_ROT_RD;
      end
      S_POP_TAKE: begin
        head_d = idx_inc(head_q);
        live_d = live_q - CNT_W'(1);
        if (live_q == CNT_W'(1)) begin
          surv_d  = SURV_W'(rdata_q);
          state_d = S_OUT;
        end else begin
          state_d = S_MOD_START;
        end
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      live_q  <= '0;
      turns_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      live_q  <= live_d;
      turns_q <= turns_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    k_q        <= k_d;
    load_val_q <= load_val_d;
    surv_q     <= surv_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[tail_q] <= mem_wdata;
    end
    rdata_q <= mem[head_q];
  end

  assign survivor_o = $signed(surv_q);

  `JSRQ_ASSERT_IMP(a_occupancy, state_q != S_IDLE, IDX_W'(tail_q - head_q) == live_q, "queue indices disagree with occupancy")
  `JSRQ_ASSERT_IMP(a_turns_below, state_q == S_ROT_RD || state_q == S_ROT_WR, turns_q < live_q, "rotation count not reduced")
  `JSRQ_ASSERT_IMP(a_done_waiting, mod_rsp.done, state_q == S_MOD_WAIT, "remainder arrived outside wait")
  `JSRQ_ASSERT_NXT(a_empty_direct, in_valid_i && in_ready_o && people_count_i == '0, out_valid_o && surv_q == SURV_NONE, "empty count not answered at once")

endmodule

// ===== bench/josephus_survivor_ring_queue_core_test.sv =====
// Self-checking bench for josephus_survivor_ring_queue_core: directed and random
// queries, back-pressure and idle gaps, each survivor compared with a local predictor.
// Depends on jsrq_pkg and the core RTL only.
`timescale 1ns / 100ps

module josephus_survivor_ring_queue_core_test;
  import jsrq_pkg::*;

  localparam int unsigned CLK_HALF    = 10;
  localparam int unsigned SETTLE_PAD  = 64;
  localparam int unsigned LONG_HOLD   = 3000;
  localparam int unsigned REPORT_MAX  = 10;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [jsrq_pkg::PEOPLE_W-1:0]      people_count = '0;
  logic [jsrq_pkg::STEP_W-1:0]        step_count = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic signed [jsrq_pkg::SURV_W-1:0] survivor;

  // Survivors still owed by the core, oldest first.
  logic [jsrq_pkg::SURV_W-1:0] pending_survivors[$];
  int unsigned error_count = 0;
  bit          idling_on = 1'b1;
  int unsigned hold_request = 0;

  josephus_survivor_ring_queue_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .people_count_i (people_count),
    .step_count_i   (step_count),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .survivor_o     (survivor)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Plays the elimination out on a queue of numbers, one removal per round.
  function automatic logic [jsrq_pkg::SURV_W-1:0] predict_survivor(
    input logic [jsrq_pkg::PEOPLE_W-1:0] n_in,
    input logic [jsrq_pkg::STEP_W-1:0]   k_in
  );
    int ring[$];
    int people;
    int turns;
    int last;
    people = (int'(n_in) > jsrq_pkg::MAX_LIVE) ? jsrq_pkg::MAX_LIVE : int'(n_in);
    if (people == 0) begin
      return jsrq_pkg::SURV_NONE;
    end
    last = 0;
    for (int p = 1; p <= people; p++) begin
      ring.push_back(p);
    end
    while (ring.size() > 0) begin
      turns = (k_in > 1) ? (int'(k_in) - 1) % ring.size() : 0;
      repeat (turns) ring.push_back(ring.pop_front());
      last = ring.pop_front();
    end
    return SURV_W'(last);
  endfunction

  // Offers one word and returns at the edge where it is taken.
  task automatic send_query(
    input logic [jsrq_pkg::PEOPLE_W-1:0] n_in,
    input logic [jsrq_pkg::STEP_W-1:0]   k_in
  );
    if (idling_on && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    people_count <= n_in;
    step_count   <= k_in;
    do @(posedge clk_i); while (!in_ready);
    pending_survivors.push_back(predict_survivor(n_in, k_in));
  endtask

  // Stops offering and waits until every owed survivor has arrived.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_survivors.size() != 0);
  endtask

  // Mostly short rings so the run stays brief; a few at or beyond capacity.
  task automatic send_random_query();
    logic [jsrq_pkg::PEOPLE_W-1:0] n_pick;
    logic [jsrq_pkg::STEP_W-1:0]   k_pick;
    int unsigned                   roll;
    roll = $urandom_range(0, 99);
    if (roll < 90) begin
      n_pick = PEOPLE_W'($urandom_range(0, 24));
    end else if (roll < 95) begin
      n_pick = PEOPLE_W'($urandom_range(25, 127));
    end else begin
      n_pick = PEOPLE_W'($urandom_range(128, 255));
    end
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      k_pick = STEP_W'($urandom_range(0, 10));
    end else if (roll < 70) begin
      k_pick = STEP_W'($urandom_range(0, 300));
    end else begin
      k_pick = STEP_W'($urandom);
    end
    send_query(n_pick, k_pick);
  endtask

  // Receiver: checks each taken word and decides ready for the next cycle.
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    logic [jsrq_pkg::SURV_W-1:0] wanted;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid && out_ready) begin
        if (pending_survivors.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_MAX) begin
            $display("unexpected survivor word %0d", survivor);
          end
        end else begin
          wanted = pending_survivors.pop_front();
          if (survivor !== wanted) begin
            error_count++;
            if (error_count <= REPORT_MAX) begin
              $display("survivor mismatch: expected %0d, got %0d",
                       $signed(wanted), survivor);
            end
          end
        end
      end
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic test_directed();
    send_query(8'd0, 16'd0);
    send_query(8'd0, 16'hFFFF);
    send_query(8'd1, 16'd0);
    send_query(8'd1, 16'd1);
    send_query(8'd1, 16'hFFFF);
    send_query(8'd2, 16'd2);
    send_query(8'd7, 16'd3);
    send_query(8'd41, 16'd3);
    send_query(8'd5, 16'd0);
    send_query(8'd10, 16'hFFFF);
    send_query(8'd127, 16'd1);
    send_query(8'd127, 16'd2);
    send_query(8'd128, 16'd5);
    send_query(8'd255, 16'hFFFF);
    send_query(8'd255, 16'd0);
    send_query(8'd126, 16'hAAAA);
    send_query(8'd3, 16'h5555);
    send_query(8'd64, 16'd128);
    wait_for_drain();
  endtask

  task automatic test_random(input int unsigned count);
    repeat (count) send_random_query();
  endtask

  // The receiver holds off long enough for a result to sit in the core while
  // further words are offered and refused.
  task automatic test_output_hold();
    hold_request = LONG_HOLD;
    repeat (4) begin
      send_query(PEOPLE_W'($urandom_range(1, 8)), STEP_W'($urandom_range(0, 6)));
    end
  endtask

  // The sender waits for every owed word before going on.
  task automatic test_sender_pause();
    wait_for_drain();
    repeat (6) send_random_query();
  endtask

  task automatic test_no_idling(input int unsigned count);
    wait_for_drain();
    idling_on = 1'b0;
    repeat (count) send_random_query();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(140);
    test_output_hold();
    test_sender_pause();
    test_random(110);
    test_no_idling(30);
    wait_for_drain();
    repeat (SETTLE_PAD) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(64'd200_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/jsrq_pkg.sv
rtl/jsrq_mod_unit.sv
rtl/josephus_survivor_ring_queue_core.sv
bench/josephus_survivor_ring_queue_core_test.sv
